FILE: rtl/rise_pkg.sv
// Package for the instruction execute step: opcodes, function codes, sizes, types.
// No dependencies.
`default_nettype none
package rise_pkg;
	localparam int unsigned DataWordsDef = 256;
	localparam logic [31:0] PcLast = 32'd1023;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_JAL   = 6'h03;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_ANDI  = 6'h0C;
	localparam logic [5:0] OP_ORI   = 6'h0D;
	localparam logic [5:0] OP_NORI  = 6'h0E;
	localparam logic [5:0] OP_LUI   = 6'h0F;
	localparam logic [5:0] OP_LB    = 6'h20;
	localparam logic [5:0] OP_LH    = 6'h21;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_LBU   = 6'h24;
	localparam logic [5:0] OP_LHU   = 6'h25;
	localparam logic [5:0] OP_SB    = 6'h28;
	localparam logic [5:0] OP_SH    = 6'h29;
	localparam logic [5:0] OP_SW    = 6'h2B;
	localparam logic [5:0] OP_HALT  = 6'h3F;

	localparam logic [5:0] FN_SLL = 6'h00;
	localparam logic [5:0] FN_SRL = 6'h02;
	localparam logic [5:0] FN_SRA = 6'h03;
	localparam logic [5:0] FN_JR  = 6'h08;
	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_XOR = 6'h26;
	localparam logic [5:0] FN_NOR = 6'h27;
	localparam logic [5:0] FN_NAND = 6'h28;
	localparam logic [5:0] FN_SLT = 6'h2A;

	localparam logic [1:0] REG_START_PC = 2'd0;
	localparam logic [1:0] REG_START_SP = 2'd1;

	// item class decided in the front end
	typedef enum logic [1:0] {
		K_PRELOAD,
		K_EXEC,
		K_MEM
	} kind_t;

	// queue entry handed from front to back
	typedef struct packed {
		kind_t       kind;
		logic [31:0] instr;
		logic [7:0]  load_index;
		logic        load_ok;
		logic [31:0] load_value;
	} item_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        halted;
		logic        err_write_zero;
		logic        err_overflow;
		logic        err_address;
		logic        err_misalign;
		logic        reg_we;
		logic [4:0]  reg_idx;
		logic [31:0] reg_val;
		logic        mem_we;
		logic [7:0]  mem_word_addr;
		logic [31:0] mem_word_val;
	} result_t;

	function automatic logic add_ovf(logic [31:0] a, logic [31:0] b, logic [31:0] r);
		return (~(a[31] ^ b[31])) & (a[31] ^ r[31]);
	endfunction

	function automatic logic sub_ovf(logic [31:0] a, logic [31:0] b, logic [31:0] r);
		return (a[31] ^ b[31]) & (a[31] ^ r[31]);
	endfunction
endpackage
`default_nettype wire

FILE: rtl/rise_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rise_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/rise_front.sv
// Front end: accepts items, classifies them and feeds a two-entry queue.
// Depends on rise_pkg.
`default_nettype none
module rise_front
	import rise_pkg::*;
#(
	parameter int unsigned DataWords = DataWordsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [31:0] instr,
	input  wire logic [7:0]  load_index,
	input  wire logic [31:0] load_value,
	output logic             q_valid,
	output item_t            q_item,
	input  wire logic        q_pop
);
	item_t      ent_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      cls;
	logic [5:0] op;

	assign op = instr[31:26];

	// classify: preload, memory access, or plain execute
	always_comb begin
		cls.instr = instr;
		cls.load_index = load_index;
		cls.load_value = load_value;
		cls.load_ok = (32'(load_index) < 32'(DataWords));
		if (opcode) begin
			cls.kind = K_PRELOAD;
		end else if (op == OP_LW || op == OP_LH || op == OP_LHU || op == OP_LB ||
				op == OP_LBU || op == OP_SW || op == OP_SH || op == OP_SB) begin
			cls.kind = K_MEM;
		end else begin
			cls.kind = K_EXEC;
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = ent_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && !push) |=> cnt_q == 2'd0)
		else $error("queue count moved without traffic");
endmodule
`default_nettype wire

FILE: rtl/rise_back.sv
// Back end: register file, PC, data memory access and result register.
// Depends on rise_pkg and rise_ram.
`default_nettype none
module rise_back
	import rise_pkg::*;
#(
	parameter int unsigned DataWords = DataWordsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire item_t       q_item,
	output logic             q_pop,
	input  wire logic        cfg_pc_we,
	input  wire logic [9:0]  cfg_pc,
	input  wire logic        cfg_sp_we,
	input  wire logic [31:0] cfg_sp,
	output logic             out_valid,
	input  wire logic        out_stall,
	output result_t          res
);
	localparam int unsigned Aw = $clog2(DataWords);
	localparam int unsigned ClrCnt = DataWords;
	localparam logic [31:0] AddrLast = 32'(DataWords * 4 - 1);

	logic [31:0] rf_q [32];
	logic [31:0] pc_q;
	logic        mem_wait_q;
	logic        clr_q;
	logic [Aw:0] clr_cnt_q;
	logic        out_valid_q;
	result_t     res_q;

	logic [31:0] ins;
	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sh;
	logic [31:0] a, b, imm, simm, addr, npc4;
	logic [31:0] mword;
	logic        can_out, fire;
	result_t     r;
	logic        wr, mw, stop, busy_first;
	logic [4:0]  widx;
	logic [31:0] wval, mval, npc, off;
	logic [4:0]  sft;
	logic [Aw-1:0] ram_waddr, ram_raddr;
	logic [31:0] ram_wdata;
	logic        ram_we;
	logic [31:0] hh, yy;

	assign ins = q_item.instr;
	assign op = ins[31:26];
	assign rs = ins[25:21];
	assign rt = ins[20:16];
	assign rd = ins[15:11];
	assign sh = ins[10:6];
	assign fn = ins[5:0];
	assign imm = {16'd0, ins[15:0]};
	assign simm = {{16{ins[15]}}, ins[15:0]};
	assign a = rf_q[rs];
	assign b = rf_q[rt];
	assign addr = a + simm;
	assign npc4 = pc_q + 32'd4;
	assign sft = {addr[1:0], 3'b000};

	assign can_out = !out_valid_q || !out_stall;
	// memory ops first read the word from the data memory, then execute
	assign busy_first = q_valid && q_item.kind == K_MEM && !mem_wait_q && !clr_q;
	assign fire = q_valid && can_out && !clr_q && (q_item.kind != K_MEM || mem_wait_q);
	assign q_pop = fire;

	// execute one item
	always_comb begin
		r = '0;
		r.next_pc = pc_q;
		wr = 1'b0;
		mw = 1'b0;
		stop = 1'b0;
		widx = 5'd0;
		wval = 32'd0;
		mval = 32'd0;
		npc = npc4;
		off = {simm[29:0], 2'b00};
		hh = {16'd0, 16'(mword >> sft)};
		yy = {24'd0, 8'(mword >> sft)};
		if (q_item.kind == K_PRELOAD) begin
			if (q_item.load_ok) begin
				r.mem_we = 1'b1;
				r.mem_word_addr = q_item.load_index;
				r.mem_word_val = q_item.load_value;
			end
		end else if (pc_q > PcLast) begin
			r.halted = 1'b1;
			r.err_address = 1'b1;
		end else begin
			if (op == OP_RTYPE) begin
				wr = 1'b1;
				widx = rd;
				case (fn)
					FN_ADD: begin
						wval = a + b;
						r.err_overflow = add_ovf(a, b, wval);
					end
					FN_SUB: begin
						wval = a - b;
						r.err_overflow = sub_ovf(a, b, wval);
					end
					FN_AND: wval = a & b;
					FN_OR: wval = a | b;
					FN_XOR: wval = a ^ b;
					FN_NOR: wval = ~(a | b);
					FN_NAND: wval = ~(a & b);
					FN_SLT: wval = {31'd0, $signed(a) < $signed(b)};
					FN_SLL: wval = b << sh;
					FN_SRL: wval = b >> sh;
					FN_SRA: wval = $unsigned($signed(b) >>> sh);
					FN_JR: begin
						wr = 1'b0;
						npc = a;
					end
					default: wr = 1'b0;
				endcase
			end else if (op == OP_HALT) begin
				stop = 1'b1;
			end else if (op == OP_J || op == OP_JAL) begin
				npc = {npc4[31:28], ins[25:0], 2'b00};
				if (op == OP_JAL) begin
					wr = 1'b1;
					widx = 5'd31;
					wval = npc4;
				end
			end else if (q_item.kind == K_MEM) begin
				r.err_overflow = add_ovf(a, simm, addr);
				if (addr > AddrLast) begin
					r.err_address = 1'b1;
					stop = 1'b1;
				end
				if (((op == OP_LW || op == OP_SW) && addr[1:0] != 2'b00) ||
						((op == OP_LH || op == OP_LHU || op == OP_SH) && addr[0])) begin
					r.err_misalign = 1'b1;
					stop = 1'b1;
				end
				if (!stop) begin
					widx = rt;
					case (op)
						OP_LW: begin wr = 1'b1; wval = mword; end
						OP_LH: begin wr = 1'b1; wval = {{16{hh[15]}}, hh[15:0]}; end
						OP_LHU: begin wr = 1'b1; wval = hh; end
						OP_LB: begin wr = 1'b1; wval = {{24{yy[7]}}, yy[7:0]}; end
						OP_LBU: begin wr = 1'b1; wval = yy; end
						OP_SW: begin mw = 1'b1; mval = b; end
						OP_SH: begin
							mw = 1'b1;
							mval = (mword & ~(32'h0000FFFF << sft)) |
								({16'd0, b[15:0]} << sft);
						end
						default: begin
							mw = 1'b1;
							mval = (mword & ~(32'h000000FF << sft)) |
								({24'd0, b[7:0]} << sft);
						end
					endcase
				end else if (op != OP_SW && op != OP_SH && op != OP_SB && rt == 5'd0) begin
					r.err_write_zero = 1'b1;
				end
			end else begin
				wr = 1'b1;
				widx = rt;
				case (op)
					OP_ADDI: begin
						wval = a + simm;
						r.err_overflow = add_ovf(a, simm, wval);
					end
					OP_LUI: wval = {ins[15:0], 16'd0};
					OP_ANDI: wval = a & imm;
					OP_ORI: wval = a | imm;
					OP_NORI: wval = ~(a | imm);
					OP_SLTI: wval = {31'd0, $signed(a) < $signed(simm)};
					OP_BEQ, OP_BNE: begin
						wr = 1'b0;
						if ((op == OP_BEQ) == (a == b)) begin
							npc = npc4 + off;
							r.err_overflow = add_ovf(npc4, off, npc);
						end
					end
					default: wr = 1'b0;
				endcase
			end
			if (wr && widx == 5'd0) begin
				r.err_write_zero = 1'b1;
				wr = 1'b0;
			end
			if (stop) begin
				r.halted = 1'b1;
			end else begin
				r.reg_we = wr;
				r.reg_idx = wr ? widx : 5'd0;
				r.reg_val = wr ? wval : 32'd0;
				r.mem_we = mw;
				r.mem_word_addr = mw ? 8'(addr[31:2]) : 8'd0;
				r.mem_word_val = mw ? mval : 32'd0;
				r.next_pc = npc;
				if (npc > PcLast) begin
					r.halted = 1'b1;
					r.err_address = 1'b1;
				end
			end
		end
	end

	// data memory port: clear sweep, preload or store
	always_comb begin
		ram_raddr = Aw'(addr[31:2]);
		ram_we = 1'b0;
		ram_waddr = Aw'(addr[31:2]);
		ram_wdata = mval;
		if (clr_q) begin
			ram_we = 1'b1;
			ram_waddr = clr_cnt_q[Aw-1:0];
			ram_wdata = 32'd0;
		end else if (fire && q_item.kind == K_PRELOAD && q_item.load_ok) begin
			ram_we = 1'b1;
			ram_waddr = Aw'(q_item.load_index);
			ram_wdata = q_item.load_value;
		end else if (fire && r.mem_we && q_item.kind == K_MEM) begin
			ram_we = 1'b1;
		end
	end

	rise_ram #(.Width(32), .Depth(DataWords)) u_dmem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (mword)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 32'd0;
			mem_wait_q <= 1'b0;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (Aw+1)'(ClrCnt - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (busy_first) begin
				mem_wait_q <= 1'b1;
			end else if (fire) begin
				mem_wait_q <= 1'b0;
			end
			if (cfg_pc_we) begin
				pc_q <= {22'd0, cfg_pc};
			end else if (fire) begin
				pc_q <= r.next_pc;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// register file: reset values, configuration and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) begin
				rf_q[i] <= 32'd0;
			end
		end else begin
			if (fire && r.reg_we) begin
				rf_q[r.reg_idx] <= r.reg_val;
			end
			if (cfg_sp_we) begin
				rf_q[29] <= cfg_sp;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= r;
		end
	end

	assign out_valid = out_valid_q;
	assign res = res_q;

	assert property (@(posedge clk) disable iff (!arst_n) fire |-> !clr_q)
		else $error("item executed during memory clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q && $stable(res_q))
		else $error("stalled result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && q_item.kind == K_MEM) |-> mem_wait_q)
		else $error("memory op fired without read cycle");
	assert property (@(posedge clk) disable iff (!arst_n) rf_q[0] == 32'd0)
		else $error("register zero written");
endmodule
`default_nettype wire

FILE: rtl/risc_instruction_execute_step.sv
// Top level of the instruction execute step: front queue, back end, APB registers.
// Depends on rise_pkg, rise_front, rise_back.
//
//  channel | signals                                      | direction
//  in      | in_valid/in_stall, opcode, instr, load_*      | into block
//  out     | out_valid/out_stall, next_pc ... mem_word_val | out of block
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata       | APB
//
// Preload and plain instructions execute directly in the back end; loads and
// stores first do the synchronous data memory read, then execute and write back.
// After reset all DATA_WORDS data memory words are cleared; no item runs then.
// The two-entry queue and output register let input and output stall apart.
`default_nettype none
module risc_instruction_execute_step
	import rise_pkg::*;
#(
	parameter int unsigned DATA_WORDS = DataWordsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [31:0] instr,
	input  wire logic [7:0]  load_index,
	input  wire logic [31:0] load_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      next_pc,
	output logic             halted,
	output logic             err_write_zero,
	output logic             err_overflow,
	output logic             err_address,
	output logic             err_misalign,
	output logic             reg_we,
	output logic [4:0]       reg_idx,
	output logic [31:0]      reg_val,
	output logic             mem_we,
	output logic [7:0]       mem_word_addr,
	output logic [31:0]      mem_word_val,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic        q_valid, q_pop;
	item_t       q_item;
	result_t     res;
	logic        wr_en;
	logic [9:0]  start_pc_q;
	logic [31:0] start_sp_q;
	logic        pc_we, sp_we;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign pc_we = wr_en && paddr[2] == REG_START_PC[0];
	assign sp_we = wr_en && paddr[2] == REG_START_SP[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q <= 10'd0;
			start_sp_q <= 32'd0;
		end else begin
			if (pc_we) begin
				start_pc_q <= pwdata[9:0];
			end
			if (sp_we) begin
				start_sp_q <= pwdata;
			end
		end
	end

	assign prdata = paddr[2] ? start_sp_q : {22'd0, start_pc_q};

	rise_front #(.DataWords(DATA_WORDS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.instr      (instr),
		.load_index (load_index),
		.load_value (load_value),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	rise_back #(.DataWords(DATA_WORDS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.cfg_pc_we (pc_we),
		.cfg_pc    (pwdata[9:0]),
		.cfg_sp_we (sp_we),
		.cfg_sp    (pwdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign next_pc = res.next_pc;
	assign halted = res.halted;
	assign err_write_zero = res.err_write_zero;
	assign err_overflow = res.err_overflow;
	assign err_address = res.err_address;
	assign err_misalign = res.err_misalign;
	assign reg_we = res.reg_we;
	assign reg_idx = res.reg_idx;
	assign reg_val = res.reg_val;
	assign mem_we = res.mem_we;
	assign mem_word_addr = res.mem_word_addr;
	assign mem_word_val = res.mem_word_val;

	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled output dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pc_we && sp_we) == 1'b0)
		else $error("two registers written at once");
endmodule
`default_nettype wire
